[design/hkmc_pkg.sv]
// Types, codes and direction tables shared by the hunt-and-kill maze carver.
`default_nettype none
package hkmc_pkg;

  localparam int CW = 6;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam logic [1:0] STAT_STARTED  = 2'd0;
  localparam logic [1:0] STAT_CARVED   = 2'd1;
  localparam logic [1:0] STAT_HUNTED   = 2'd2;
  localparam logic [1:0] STAT_FINISHED = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [3:0][1:0] ORDER_INIT = {DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP};

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] start_x;
    logic [CW-1:0] start_y;
    logic [7:0]    swap_picks;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [CW-1:0] wall_x;
    logic [CW-1:0] wall_y;
    logic [CW-1:0] cell_x;
    logic [CW-1:0] cell_y;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MARK,
    ST_TRY_RD,
    ST_TRY_CHK,
    ST_CARVE,
    ST_HUNT_CUR,
    ST_HUNT_UP,
    ST_HUNT_DN,
    ST_HUNT_LATCH,
    ST_HUNT_SCAN,
    ST_OUT
  } state_t;

  function automatic logic signed [7:0] ofs_x(input logic [1:0] d);
    case (d)
      DIR_LEFT:  ofs_x = -8'sd2;
      DIR_RIGHT: ofs_x = 8'sd2;
      default:   ofs_x = 8'sd0;
    endcase
  endfunction

  function automatic logic signed [7:0] ofs_y(input logic [1:0] d);
    case (d)
      DIR_UP:   ofs_y = -8'sd2;
      DIR_DOWN: ofs_y = 8'sd2;
      default:  ofs_y = 8'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/hkmc_in_if.sv]
// Command channel of the maze carver: valid/ready with a command item.
`default_nettype none
interface hkmc_in_if;
  logic          valid;
  logic          ready;
  hkmc_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/hkmc_out_if.sv]
// Result channel of the maze carver: valid/ready with a result item.
`default_nettype none
interface hkmc_out_if;
  logic          valid;
  logic          ready;
  hkmc_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/hunt_and_kill_maze_carver.sv]
// Hunt-and-kill maze carver: top level with grid row memory and step sequencer.
//
// Usage: each item on cmd gives exactly one item on res. A start item (kind 0)
// clears the GRID_H x GRID_W grid one row per cycle, marks the start cell and
// answers "started". A step item (kind 1) shuffles the direction order, then
// probes up to four neighbors, each one grid-row read, and carves. When no
// neighbor is open, a hunt walks the odd rows; per row it reads three grid
// rows and then scans one odd column per cycle. The row memory has a single
// read port.
// cmd.ready is high only while the sequencer is idle; one item is worked at a
// time. Results sit in an output register, so the next command is taken while
// a result waits; a stalled receiver holds the sequencer at its result slot.
// Reset: no maze, direction order up, down, left, right, current cell zero;
// steps before the first start report "finished". The grid is cleared by each
// start item, never at reset.
`default_nettype none
module hunt_and_kill_maze_carver #(
  parameter int GRID_W = 31,
  parameter int GRID_H = 31
) (
  input  wire        clk,
  input  wire        rst,
  hkmc_in_if.sink    cmd,
  hkmc_out_if.source res
);

  localparam int CW  = hkmc_pkg::CW;
  localparam int CIW = $clog2(GRID_W);
  localparam int RW  = $clog2(GRID_H);
  localparam int TOP_X = ((GRID_W - 2) % 2 == 0) ? GRID_W - 3 : GRID_W - 2;
  localparam int TOP_Y = ((GRID_H - 2) % 2 == 0) ? GRID_H - 3 : GRID_H - 2;

  hkmc_pkg::state_t state, state_next;

  // grid row memory
  logic [GRID_W-1:0] grid [GRID_H];
  logic [GRID_W-1:0] rd_data;
  logic [RW-1:0]     rd_addr;
  logic              wr_en, wr_clr;
  logic [RW-1:0]     wr_row;
  logic [CIW-1:0]    wr_col;

  always_ff @(posedge clk) begin
    rd_data <= grid[rd_addr];
    if (wr_clr) begin
      grid[wr_row] <= '0;
    end else if (wr_en) begin
      grid[wr_row][wr_col] <= 1'b1;
    end
  end

  logic [CW-1:0]     here_x, here_x_next, here_y, here_y_next;
  logic              finished, finished_next;
  logic [3:0][1:0]   dir_order, dir_order_next, shuf;
  logic [1:0]        try_i, try_i_next;
  logic [CW-1:0]     hunt_r, hunt_r_next, hunt_c, hunt_c_next;
  logic [RW-1:0]     clr_row, clr_row_next;
  logic [GRID_W-1:0] row_cur, row_up, row_dn;
  logic [1:0]        r_status, r_status_next;
  logic [CW-1:0]     r_wx, r_wx_next, r_wy, r_wy_next;
  logic              out_valid;
  hkmc_pkg::res_t    out_data;
  logic              out_load;

  logic [CW-1:0]     sx, sy;
  logic [1:0]        dir;
  logic signed [7:0] nx8, ny8, wx8, wy8, ox, oy;
  logic              nb_ok, nb_open;
  logic [6:0]        hc7, hr7, hl7, hrt7, c_adv, r_adv, up_row, dn_row;
  logic              col_in, row_in, open_u, open_d, open_l, open_r, hunt_hit;
  logic              hunt_last_col, hunt_last_row;

  always_comb begin : shuffle_blk
    logic [1:0] t;
    logic [1:0] j;
    shuf = dir_order;
    for (int k = 0; k < 4; k++) begin
      j = cmd.data.swap_picks[2*k +: 2];
      t = shuf[k];
      shuf[k] = shuf[j];
      shuf[j] = t;
    end
  end

  assign sx = cmd.data.start_x | CW'(1);
  assign sy = cmd.data.start_y | CW'(1);

  // neighbor probe for the current direction slot
  assign dir = dir_order[try_i];
  assign ox  = hkmc_pkg::ofs_x(dir);
  assign oy  = hkmc_pkg::ofs_y(dir);
  assign nx8 = $signed({2'b00, here_x}) + ox;
  assign ny8 = $signed({2'b00, here_y}) + oy;
  assign wx8 = $signed({2'b00, here_x}) + (ox >>> 1);
  assign wy8 = $signed({2'b00, here_y}) + (oy >>> 1);
  assign nb_ok = (nx8 > 0) && (nx8 < GRID_W - 1) && (ny8 > 0) && (ny8 < GRID_H - 1);
  assign nb_open = !rd_data[nx8[CIW-1:0]];

  // hunt scan at (hunt_c, hunt_r)
  assign hc7    = {1'b0, hunt_c};
  assign hr7    = {1'b0, hunt_r};
  assign hl7    = (hc7 >= 7'd3) ? hc7 - 7'd2 : hc7;
  assign hrt7   = (hc7 + 7'd2 <= GRID_W - 2) ? hc7 + 7'd2 : hc7;
  assign up_row = (hr7 >= 7'd3) ? hr7 - 7'd2 : hr7;
  assign dn_row = (hr7 + 7'd2 < GRID_H) ? hr7 + 7'd2 : hr7;
  assign col_in = hc7 <= GRID_W - 2;
  assign row_in = hr7 <= GRID_H - 2;
  assign open_u = col_in && (hr7 >= 7'd3) && !row_up[hunt_c[CIW-1:0]];
  assign open_d = col_in && (hr7 + 7'd2 <= GRID_H - 2) && !row_dn[hunt_c[CIW-1:0]];
  assign open_l = row_in && (hc7 >= 7'd3) && !row_cur[hl7[CIW-1:0]];
  assign open_r = row_in && (hc7 + 7'd2 <= GRID_W - 2) && !row_cur[hrt7[CIW-1:0]];
  assign hunt_hit = row_cur[hunt_c[CIW-1:0]] && (open_u || open_d || open_l || open_r);
  assign c_adv  = hc7 + 7'd2;
  assign r_adv  = hr7 + 7'd2;
  assign hunt_last_col = c_adv >= GRID_W;
  assign hunt_last_row = r_adv >= GRID_H;

  assign out_load = (state == hkmc_pkg::ST_OUT) && (!out_valid || res.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hkmc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.data.kind == hkmc_pkg::KIND_START) begin
            state_next = hkmc_pkg::ST_CLEAR;
          end else if (finished) begin
            state_next = hkmc_pkg::ST_OUT;
          end else begin
            state_next = hkmc_pkg::ST_TRY_RD;
          end
        end
      end
      hkmc_pkg::ST_CLEAR: begin
        if (clr_row == RW'(GRID_H - 1)) state_next = hkmc_pkg::ST_MARK;
      end
      hkmc_pkg::ST_MARK:  state_next = hkmc_pkg::ST_OUT;
      hkmc_pkg::ST_TRY_RD: begin
        if (nb_ok) state_next = hkmc_pkg::ST_TRY_CHK;
        else if (try_i == 2'd3) state_next = hkmc_pkg::ST_HUNT_CUR;
      end
      hkmc_pkg::ST_TRY_CHK: begin
        if (nb_open) state_next = hkmc_pkg::ST_CARVE;
        else if (try_i == 2'd3) state_next = hkmc_pkg::ST_HUNT_CUR;
        else state_next = hkmc_pkg::ST_TRY_RD;
      end
      hkmc_pkg::ST_CARVE:      state_next = hkmc_pkg::ST_OUT;
      hkmc_pkg::ST_HUNT_CUR:   state_next = hkmc_pkg::ST_HUNT_UP;
      hkmc_pkg::ST_HUNT_UP:    state_next = hkmc_pkg::ST_HUNT_DN;
      hkmc_pkg::ST_HUNT_DN:    state_next = hkmc_pkg::ST_HUNT_LATCH;
      hkmc_pkg::ST_HUNT_LATCH: state_next = hkmc_pkg::ST_HUNT_SCAN;
      hkmc_pkg::ST_HUNT_SCAN: begin
        if (hunt_hit) state_next = hkmc_pkg::ST_OUT;
        else if (hunt_last_col) begin
          state_next = hunt_last_row ? hkmc_pkg::ST_OUT : hkmc_pkg::ST_HUNT_CUR;
        end
      end
      hkmc_pkg::ST_OUT: begin
        if (out_load) state_next = hkmc_pkg::ST_IDLE;
      end
      default: state_next = hkmc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    here_x_next    = here_x;
    here_y_next    = here_y;
    finished_next  = finished;
    dir_order_next = dir_order;
    try_i_next     = try_i;
    hunt_r_next    = hunt_r;
    hunt_c_next    = hunt_c;
    clr_row_next   = clr_row;
    r_status_next  = r_status;
    r_wx_next      = r_wx;
    r_wy_next      = r_wy;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_clr         = 1'b0;
    wr_row         = '0;
    wr_col         = '0;
    cmd.ready      = 1'b0;
    case (state)
      hkmc_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          r_wx_next = '0;
          r_wy_next = '0;
          if (cmd.data.kind == hkmc_pkg::KIND_START) begin
            here_x_next    = (sx > TOP_X) ? CW'(TOP_X) : sx;
            here_y_next    = (sy > TOP_Y) ? CW'(TOP_Y) : sy;
            dir_order_next = hkmc_pkg::ORDER_INIT;
            finished_next  = 1'b0;
            clr_row_next   = '0;
            r_status_next  = hkmc_pkg::STAT_STARTED;
          end else if (finished) begin
            r_status_next  = hkmc_pkg::STAT_FINISHED;
          end else begin
            dir_order_next = shuf;
            try_i_next     = 2'd0;
          end
        end
      end
      hkmc_pkg::ST_CLEAR: begin
        wr_clr       = 1'b1;
        wr_row       = clr_row;
        clr_row_next = clr_row + RW'(1);
      end
      hkmc_pkg::ST_MARK: begin
        wr_en  = 1'b1;
        wr_row = here_y[RW-1:0];
        wr_col = here_x[CIW-1:0];
      end
      hkmc_pkg::ST_TRY_RD: begin
        rd_addr = ny8[RW-1:0];
        if (!nb_ok && try_i != 2'd3) try_i_next = try_i + 2'd1;
        if (!nb_ok && try_i == 2'd3) begin
          hunt_r_next = CW'(1);
          hunt_c_next = CW'(1);
        end
      end
      hkmc_pkg::ST_TRY_CHK: begin
        if (nb_open) begin
          wr_en         = 1'b1;
          wr_row        = wy8[RW-1:0];
          wr_col        = wx8[CIW-1:0];
          r_wx_next     = wx8[CW-1:0];
          r_wy_next     = wy8[CW-1:0];
          r_status_next = hkmc_pkg::STAT_CARVED;
        end else if (try_i == 2'd3) begin
          hunt_r_next = CW'(1);
          hunt_c_next = CW'(1);
        end else begin
          try_i_next = try_i + 2'd1;
        end
      end
      hkmc_pkg::ST_CARVE: begin
        wr_en       = 1'b1;
        wr_row      = ny8[RW-1:0];
        wr_col      = nx8[CIW-1:0];
        here_x_next = nx8[CW-1:0];
        here_y_next = ny8[CW-1:0];
      end
      hkmc_pkg::ST_HUNT_CUR: rd_addr = hunt_r[RW-1:0];
      hkmc_pkg::ST_HUNT_UP:  rd_addr = up_row[RW-1:0];
      hkmc_pkg::ST_HUNT_DN:  rd_addr = dn_row[RW-1:0];
      hkmc_pkg::ST_HUNT_SCAN: begin
        if (hunt_hit) begin
          here_x_next   = hunt_c;
          here_y_next   = hunt_r;
          r_status_next = hkmc_pkg::STAT_HUNTED;
        end else if (hunt_last_col) begin
          hunt_c_next = CW'(1);
          hunt_r_next = r_adv[CW-1:0];
          if (hunt_last_row) begin
            finished_next = 1'b1;
            r_status_next = hkmc_pkg::STAT_FINISHED;
          end
        end else begin
          hunt_c_next = c_adv[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hkmc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      finished  <= 1'b1;
      here_x    <= '0;
      here_y    <= '0;
      dir_order <= hkmc_pkg::ORDER_INIT;
    end else begin
      state     <= state_next;
      finished  <= finished_next;
      here_x    <= here_x_next;
      here_y    <= here_y_next;
      dir_order <= dir_order_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    try_i    <= try_i_next;
    hunt_r   <= hunt_r_next;
    hunt_c   <= hunt_c_next;
    clr_row  <= clr_row_next;
    r_status <= r_status_next;
    r_wx     <= r_wx_next;
    r_wy     <= r_wy_next;
    case (state)
      hkmc_pkg::ST_HUNT_UP:    row_cur <= rd_data;
      hkmc_pkg::ST_HUNT_DN:    row_up  <= rd_data;
      hkmc_pkg::ST_HUNT_LATCH: row_dn  <= rd_data;
      default: ;
    endcase
    if (out_load) begin
      out_data.status <= r_status;
      out_data.wall_x <= r_wx;
      out_data.wall_y <= r_wy;
      out_data.cell_x <= here_x;
      out_data.cell_y <= here_y;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule
`default_nettype wire

[tb/hkmc_checker.sv]
// Checker for the maze carver: mirrors the grid walk and compares each result item.
module hkmc_checker #(
  parameter int GRID_W = 31,
  parameter int GRID_H = 31
) (
  input  logic clk,
  input  logic rst,
  hkmc_in_if   cmd,
  hkmc_out_if  res,
  output int   errors,
  output int   pending
);

  localparam int CW = hkmc_pkg::CW;
  localparam int STEP_DX [4] = '{0, 0, -2, 2};
  localparam int STEP_DY [4] = '{-2, 2, 0, 0};

  bit              grid [GRID_H][GRID_W];
  logic [3:0][1:0] dir_ord;
  int              here_x;
  int              here_y;
  bit              done;
  hkmc_pkg::res_t  want_q [$];

  function automatic bit is_open(int cx, int cy);
    if (cx <= 0 || cx >= GRID_W - 1 || cy <= 0 || cy >= GRID_H - 1) return 1'b0;
    return !grid[cy][cx];
  endfunction

  function automatic int odd_coord(logic [CW-1:0] v, int size);
    int top;
    int c;
    top = size - 2;
    if (top % 2 == 0) top = top - 1;
    c = int'(v) | 1;
    return (c > top) ? top : c;
  endfunction

  function automatic hkmc_pkg::res_t walk_maze(hkmc_pkg::cmd_t c);
    hkmc_pkg::res_t r;
    int             k;
    int             s;
    int             xx;
    int             yy;
    int             nx;
    int             ny;
    logic [1:0]     pick;
    logic [1:0]     d;
    logic [1:0]     t;
    r = '0;
    if (c.kind == hkmc_pkg::KIND_START) begin
      foreach (grid[y, x]) grid[y][x] = 1'b0;
      dir_ord = hkmc_pkg::ORDER_INIT;
      here_x = odd_coord(c.start_x, GRID_W);
      here_y = odd_coord(c.start_y, GRID_H);
      grid[here_y][here_x] = 1'b1;
      done = 1'b0;
      r.status = hkmc_pkg::STAT_STARTED;
    end else if (done) begin
      r.status = hkmc_pkg::STAT_FINISHED;
    end else begin
      for (k = 0; k < 4; k++) begin
        pick = c.swap_picks[2*k +: 2];
        t = dir_ord[k];
        dir_ord[k] = dir_ord[pick];
        dir_ord[pick] = t;
      end
      r.status = hkmc_pkg::STAT_FINISHED;
      for (k = 0; k < 4 && r.status == hkmc_pkg::STAT_FINISHED; k++) begin
        d = dir_ord[k];
        nx = here_x + STEP_DX[d];
        ny = here_y + STEP_DY[d];
        if (is_open(nx, ny)) begin
          r.status = hkmc_pkg::STAT_CARVED;
          r.wall_x = CW'((here_x + nx) / 2);
          r.wall_y = CW'((here_y + ny) / 2);
          grid[(here_y + ny) / 2][(here_x + nx) / 2] = 1'b1;
          grid[ny][nx] = 1'b1;
          here_x = nx;
          here_y = ny;
        end
      end
      // hunt: row-major over odd cells, first path cell with an open neighbor
      for (yy = 1; yy < GRID_H && r.status == hkmc_pkg::STAT_FINISHED; yy += 2)
        for (xx = 1; xx < GRID_W && r.status == hkmc_pkg::STAT_FINISHED; xx += 2)
          if (grid[yy][xx])
            for (s = 0; s < 4 && r.status == hkmc_pkg::STAT_FINISHED; s++)
              if (is_open(xx + STEP_DX[s], yy + STEP_DY[s])) begin
                r.status = hkmc_pkg::STAT_HUNTED;
                here_x = xx;
                here_y = yy;
              end
      if (r.status == hkmc_pkg::STAT_FINISHED) done = 1'b1;
    end
    r.cell_x = CW'(here_x);
    r.cell_y = CW'(here_y);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    hkmc_pkg::res_t want;
    hkmc_pkg::res_t got;
    if (rst) begin
      foreach (grid[y, x]) grid[y][x] = 1'b0;
      dir_ord = hkmc_pkg::ORDER_INIT;
      here_x = 0;
      here_y = 0;
      done = 1'b1;
      want_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        got = res.data;
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = want_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("wall_x", want.wall_x, got.wall_x);
          check_field("wall_y", want.wall_y, got.wall_y);
          check_field("cell_x", want.cell_x, got.cell_x);
          check_field("cell_y", want.cell_y, got.cell_y);
        end
      end
      if (cmd.valid && cmd.ready) want_q.push_back(walk_maze(cmd.data));
    end
    pending = want_q.size();
  end

endmodule

[tb/hunt_and_kill_maze_carver_test.sv]
// Test top for the maze carver: clock, reset, command stimulus and verdict.
module hunt_and_kill_maze_carver_test;

  localparam int CW         = hkmc_pkg::CW;
  localparam int GRID_W     = 31;
  localparam int GRID_H     = 31;
  localparam int RAND_ITEMS = 430;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   errors;
  int   pending;

  hkmc_in_if  cmd_ch ();
  hkmc_out_if res_ch ();

  hunt_and_kill_maze_carver #(.GRID_W(GRID_W), .GRID_H(GRID_H)) DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  hkmc_checker #(.GRID_W(GRID_W), .GRID_H(GRID_H)) CHK (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_cmd(logic kind, logic [CW-1:0] sx, logic [CW-1:0] sy,
                          logic [7:0] picks);
    hkmc_pkg::cmd_t c;
    c.kind = kind;
    c.start_x = sx;
    c.start_y = sy;
    c.swap_picks = picks;
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.data <= c;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_maze(logic [CW-1:0] sx, logic [CW-1:0] sy);
    send_cmd(hkmc_pkg::KIND_START, sx, sy, 8'($urandom_range(255)));
  endtask

  task automatic step_maze(logic [7:0] picks);
    send_cmd(hkmc_pkg::KIND_STEP, CW'($urandom_range(63)), CW'($urandom_range(63)), picks);
  endtask

  // drain everything in flight, then switch idle/stall rates
  task automatic set_phase(int p);
    cmd_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    case (p)
      1: begin
        idle_pct = 63;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 63;
      end
      default: begin
        idle_pct = 33;
        stall_pct = 33;
      end
    endcase
  endtask

  initial begin
    int n;
    int phase;
    int left;
    bit long_walk;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // step with no maze yet
    step_maze(8'hFF);
    start_maze(6'd0, 6'd0);
    step_maze(8'h00);
    step_maze(8'hFF);
    step_maze(8'h55);
    step_maze(8'hAA);
    step_maze(8'hE4);
    step_maze(8'h1B);
    step_maze(8'h39);
    // saturates to the bottom-right corner
    start_maze(6'd63, 6'd63);
    step_maze(8'h00);
    step_maze(8'hC6);
    step_maze(8'hFF);
    start_maze(6'd30, 6'd62);
    step_maze(8'h93);
    step_maze(8'h4E);
    start_maze(6'd28, 6'd2);
    step_maze(8'h27);
    step_maze(8'hD8);
    start_maze(6'd16, 6'd1);
    step_maze(8'h72);
    step_maze(8'h8D);

    phase = 0;
    left = 0;
    long_walk = 1'b0;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n * 4 / RAND_ITEMS != phase) begin
        phase++;
        set_phase(phase);
      end
      if (left == 0 || (!long_walk && $urandom_range(39) == 0)) begin
        if ($urandom_range(3) == 0)
          start_maze(CW'($urandom_range(63)), CW'($urandom_range(63)));
        else
          start_maze(CW'(2 * $urandom_range(14) + 1), CW'(2 * $urandom_range(14) + 1));
        // first walk runs the maze to completion across the phase changes
        long_walk = (n == 0);
        left = long_walk ? 300 : $urandom_range(60, 5);
      end else begin
        step_maze(8'($urandom_range(255)));
        left--;
        if (left == 0) long_walk = 1'b0;
      end
    end

    cmd_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
